// ===== rtl/core/aes256ctr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes256ctr_pkg
// Types, constants and round functions shared by the AES-256 CTR block.
// ----------------------------------------------------------------------------
package aes256ctr_pkg;

  localparam int NUM_ROUNDS  = 14;
  localparam int KEY_WORDS   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int BLOCK_BYTES = 16;
  localparam int COUNT_W     = 5;

  // Register index codes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 2'd3;

  localparam logic [63:0] KEY_RESET [KEY_WORDS] = '{
    64'h0001020304050607, 64'h08090A0B0C0D0E0F,
    64'h1011121314151617, 64'h18191A1B1C1D1E1F
  };

  typedef struct packed {
    logic               first_block;
    logic [63:0]        nonce_hi;
    logic [63:0]        nonce_lo;
    logic [63:0]        text_hi;
    logic [63:0]        text_lo;
    logic [COUNT_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        out_hi;
    logic [63:0]        out_lo;
    logic [COUNT_W-1:0] out_count;
  } out_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte 0 sits in the top bits of the block.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int j);
    return s[127 - 8*j -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = sbox(get_byte(s, ((c + r) % 4)*4 + r));
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(s, c*4);
      a1  = get_byte(s, c*4 + 1);
      a2  = get_byte(s, c*4 + 2);
      a3  = get_byte(s, c*4 + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(c*4)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127 - 8*(c*4 + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127 - 8*(c*4 + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127 - 8*(c*4 + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // Round constant for the even round-key halves; n is half index / 2.
  function automatic logic [7:0] rcon(input logic [2:0] n);
    logic [7:0] rc;
    case (n)
      3'd1:    rc = 8'h01;
      3'd2:    rc = 8'h02;
      3'd3:    rc = 8'h04;
      3'd4:    rc = 8'h08;
      3'd5:    rc = 8'h10;
      3'd6:    rc = 8'h20;
      3'd7:    rc = 8'h40;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // Next 128-bit round key from the two before it.
  function automatic logic [127:0] expand_half(input logic [127:0] older,
                                               input logic [127:0] newer,
                                               input logic         even,
                                               input logic [7:0]   rc);
    logic [31:0] w;
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    w = newer[31:0];
    if (even) begin
      t = {sbox(w[23:16]) ^ rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
    end else begin
      t = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    end
    w0 = older[127:96] ^ t;
    w1 = older[95:64]  ^ w0;
    w2 = older[63:32]  ^ w1;
    w3 = older[31:0]   ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/aes256ctr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes256ctr_in_if
// Valid/ready channel carrying one input block transaction.
// ----------------------------------------------------------------------------
interface aes256ctr_in_if;
  import aes256ctr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/aes256ctr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes256ctr_out_if
// Valid/ready channel carrying one result block transaction.
// ----------------------------------------------------------------------------
interface aes256ctr_out_if;
  import aes256ctr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/aes256_ctr_block_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes256_ctr_block_cipher
// AES-256 counter-mode encrypt/decrypt, one 16-byte block per transaction.
//
// Usage: the 256-bit key is written through cfg_we/cfg_index/cfg_data, one
// 64-bit word per write. Blocks enter on "item" and results leave on
// "result", both valid/ready. A block with first_block set loads its nonce
// as the counter block and restarts the block counter; later blocks use the
// incremented counter. Bytes past byte_count come back as zero.
// Pipeline: a block accepted at one edge takes the round-0 key add into the
// first stage at that edge, then moves one stage per AES round; the last
// stage is the result register. Throughput: one block per cycle unless
// result is held or the key is being expanded, set by the 15-stage round
// pipeline; the counter update is the only loop in the block path.
// Reset and key writes: the round keys are expanded one per cycle, with
// item.ready low meanwhile. Reset loads the default key.
// Stall: while result is held, empty stages still fill, so new blocks are
// taken until the pipeline is full.
// ----------------------------------------------------------------------------
module aes256_ctr_block_cipher (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       cfg_we,
  input  wire [aes256ctr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire [aes256ctr_pkg::CFG_DATA_W-1:0]       cfg_data,
  aes256ctr_in_if.sink                              item,
  aes256ctr_out_if.source                           result
);
  import aes256ctr_pkg::*;

  localparam logic [3:0] EXP_FIRST = 4'd2;
  localparam logic [3:0] EXP_LAST  = 4'(NUM_ROUNDS);

  // Key and round-key expansion
  logic [63:0]  key_word [KEY_WORDS];
  logic         busy;
  logic [3:0]   exp_idx;
  logic [127:0] round_key [EXP_FIRST:EXP_LAST];
  logic [127:0] half_older, half_newer;
  logic [127:0] src_older, src_newer, half_next;
  logic [127:0] rk [0:NUM_ROUNDS];

  // Counter state
  logic [63:0]  counter_block_hi, counter_block_lo;
  logic [31:0]  block_counter;
  logic [63:0]  cb_hi_used, cb_lo_used;
  logic [31:0]  block_counter_next;
  logic [COUNT_W-1:0] count_sat;

  // Round pipeline
  logic [NUM_ROUNDS:0]  stage_valid;
  logic [NUM_ROUNDS:0]  en;
  logic [127:0]         stage_state [0:NUM_ROUNDS-1];
  logic [127:0]         stage_text  [0:NUM_ROUNDS-1];
  logic [COUNT_W-1:0]   stage_count [0:NUM_ROUNDS-1];
  logic [127:0]         round_next  [1:NUM_ROUNDS-1];
  logic [127:0]         keystream, final_text;
  out_item_t            out_next, out_reg;
  logic                 accept;

  // Round key view: first two come straight from the key.
  always_comb begin
    rk[0] = {key_word[0], key_word[1]};
    rk[1] = {key_word[2], key_word[3]};
    for (int k = 2; k <= NUM_ROUNDS; k++) begin
      rk[k] = round_key[k];
    end
  end

  always_comb begin
    src_older = (exp_idx == EXP_FIRST) ? rk[0] : half_older;
    src_newer = (exp_idx == EXP_FIRST) ? rk[1] : half_newer;
    half_next = expand_half(src_older, src_newer, ~exp_idx[0], rcon(exp_idx[3:1]));
  end

  // Backpressure: a stage moves when it is empty or the next one moves.
  always_comb begin
    en[NUM_ROUNDS] = ~stage_valid[NUM_ROUNDS] | result.ready;
    for (int k = NUM_ROUNDS - 1; k >= 0; k--) begin
      en[k] = ~stage_valid[k] | en[k+1];
    end
  end

  assign item.ready = en[0] & ~busy;
  assign accept     = item.valid & item.ready;

  always_comb begin
    if (item.payload.first_block) begin
      cb_hi_used         = item.payload.nonce_hi;
      cb_lo_used         = item.payload.nonce_lo;
      block_counter_next = 32'd1;
    end else begin
      cb_hi_used         = counter_block_hi;
      cb_lo_used         = counter_block_lo;
      block_counter_next = block_counter + 32'd1;
    end
    count_sat = (item.payload.byte_count > COUNT_W'(BLOCK_BYTES)) ?
                COUNT_W'(BLOCK_BYTES) : item.payload.byte_count;
  end

  always_comb begin
    for (int k = 1; k < NUM_ROUNDS; k++) begin
      round_next[k] = mix_columns(sub_shift(stage_state[k-1])) ^ rk[k];
    end
    keystream  = sub_shift(stage_state[NUM_ROUNDS-1]) ^ rk[NUM_ROUNDS];
    final_text = stage_text[NUM_ROUNDS-1] ^ keystream;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (COUNT_W'(i) >= stage_count[NUM_ROUNDS-1]) begin
        final_text[127 - 8*i -: 8] = 8'h00;
      end
    end
    out_next.out_hi    = final_text[127:64];
    out_next.out_lo    = final_text[63:0];
    out_next.out_count = stage_count[NUM_ROUNDS-1];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_word[w] <= KEY_RESET[w];
      end
      busy             <= 1'b1;
      exp_idx          <= EXP_FIRST;
      counter_block_hi <= '0;
      counter_block_lo <= '0;
      block_counter    <= '0;
      stage_valid      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_WORD_0: key_word[0] <= cfg_data;
          REG_KEY_WORD_1: key_word[1] <= cfg_data;
          REG_KEY_WORD_2: key_word[2] <= cfg_data;
          REG_KEY_WORD_3: key_word[3] <= cfg_data;
          default:        key_word[0] <= key_word[0];
        endcase
        busy    <= 1'b1;
        exp_idx <= EXP_FIRST;
      end else if (busy) begin
        exp_idx <= exp_idx + 4'd1;
        if (exp_idx == EXP_LAST) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        counter_block_hi <= cb_hi_used;
        counter_block_lo <= {cb_lo_used[63:32], block_counter_next};
        block_counter    <= block_counter_next;
      end
      if (en[0]) begin
        stage_valid[0] <= accept;
      end
      for (int k = 1; k <= NUM_ROUNDS; k++) begin
        if (en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (busy && !cfg_we) begin
      round_key[exp_idx] <= half_next;
      half_older         <= src_newer;
      half_newer         <= half_next;
    end
    if (en[0]) begin
      stage_state[0] <= {cb_hi_used, cb_lo_used} ^ rk[0];
      stage_text[0]  <= {item.payload.text_hi, item.payload.text_lo};
      stage_count[0] <= count_sat;
    end
    for (int k = 1; k < NUM_ROUNDS; k++) begin
      if (en[k]) begin
        stage_state[k] <= round_next[k];
        stage_text[k]  <= stage_text[k-1];
        stage_count[k] <= stage_count[k-1];
      end
    end
    if (en[NUM_ROUNDS]) begin
      out_reg <= out_next;
    end
  end

  assign result.valid   = stage_valid[NUM_ROUNDS];
  assign result.payload = out_reg;

endmodule
`default_nettype wire
